// ===== rtl/core/assert_macros.svh =====
// Assertion macros for the RTL files of the curvature refinement block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled during rst.
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and disabled during rst.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/pcrf_pkg.sv =====
// Package with types and constants of the pressure curvature refinement block.
`timescale 1ns / 1ps
package pcrf_pkg;

  localparam int PRESSURE_WIDTH_DEFAULT = 32;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 32;

  localparam int IN_DATA_W  = 352;
  localparam int OUT_DATA_W = 8;

  localparam logic [CFG_INDEX_W-1:0] REG_THRESHOLD  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_RADIUS     = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_DIMENSIONS = 2'd2;

  localparam logic [1:0] DIMS_2D = 2'd2;
  localparam logic [1:0] DIMS_3D = 2'd3;

  localparam logic [31:0] THRESHOLD_RESET  = 32'd65536;
  localparam logic [30:0] RADIUS_RESET     = 31'd196608;

  typedef enum logic [1:0] {
    DEC_KEEP     = 2'd0,
    DEC_REFINE   = 2'd1,
    DEC_DEREFINE = 2'd2
  } decision_t;

endpackage

// ===== rtl/core/pressure_curvature_refine_flag.sv =====
// Top level of the pressure curvature refinement flag with its shared multiplier.
`timescale 1ns / 1ps
`include "assert_macros.svh"
// One cell request enters on the s_axis channel; tdata carries the seven pressures,
// the three inverse squared spacings and the block centre radius sum, and tlast marks
// the final cell of a block. On that final cell one decision request (keep, refine or
// derefine) leaves on the m_axis channel. Other cells produce no output.
// All wide products run through a single 32x32 multiplier, one limb pair per cycle,
// under a small sequencer; s_axis_tready is high only while the sequencer is idle.
// Per axis (two in 2D, three in 3D) the sequencer multiplies |lo + hi - 2*pc| by the
// inverse squared spacing, squares that and adds it to the sum; then it squares the
// threshold times pc and makes two compares, and a last cell then issues the decision.
// A 1D cell skips the products. Their work grows with the 32-bit limbs of the pressure.
// The decision sits in an output register, so a new cell is accepted while it waits;
// a later decision waits in the sequencer until that register is free.
// Reset restores the registers to defaults, clears the refine flag, sets the derefine
// flag and drops any pending decision. The user writes configuration through cfg_we,
// cfg_index and cfg_data only while no cell is in flight; the block does not check it.
module pressure_curvature_refine_flag #(
  parameter int PRESSURE_WIDTH = pcrf_pkg::PRESSURE_WIDTH_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // p_center, p_x_minus, p_x_plus, p_y_minus, p_y_plus, p_z_minus, p_z_plus,
  // inv_dx_sq, inv_dy_sq, inv_dz_sq, center_radius_sum (32 bits each, lowest first)
  input  logic [pcrf_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  // last_cell
  input  logic                             s_axis_tlast,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // decision in bits 1:0, zeros above
  output logic [pcrf_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  input  logic                             cfg_we,
  input  logic [pcrf_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [pcrf_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import pcrf_pkg::*;

  localparam int PW   = PRESSURE_WIDTH;
  localparam int LA   = (PW + 1 + 31) / 32;
  localparam int L    = (PW + 33 + 31) / 32;
  localparam int LP   = (PW + 31) / 32;
  localparam int LQ   = (PW + 32 + 31) / 32;
  localparam int OPW  = L * 32;
  localparam int ACCW = 2 * OPW;
  localparam int SUMW = ACCW + 2;
  localparam int CW   = $clog2(L);
  localparam int SHW  = $clog2(2 * L);

  typedef enum logic [3:0] {
    ST_IDLE, ST_MAG, ST_MUL, ST_MWAIT, ST_SQ, ST_ADD,
    ST_QT, ST_QSQ, ST_CMPA, ST_CMPB, ST_DECIDE
  } state_t;

  state_t state;
  state_t ret;

  logic [31:0] threshold;
  logic [30:0] radius_limit;
  logic [1:0]  dimensions;

  logic [PW-1:0] pc;
  logic [PW-1:0] lo [3];
  logic [PW-1:0] hi [3];
  logic [31:0]   inv [3];
  logic [31:0]   radius_sum;
  logic          last;
  logic          multi;
  logic [1:0]    axis;
  logic [1:0]    axis_last;

  logic [L-1:0][31:0] opa;
  logic [L-1:0][31:0] opb;
  logic [CW-1:0]      ia;
  logic [CW-1:0]      ja;
  logic [CW-1:0]      ia_last;
  logic [CW-1:0]      ja_last;
  logic [63:0]        prod;
  logic [SHW-1:0]     sh;
  logic               pvalid;
  logic [ACCW-1:0]    acc;
  logic [SUMW-1:0]    sum;

  logic any_above;
  logic all_below;
  logic out_valid;
  logic [1:0] out_dec;

  logic [PW:0]   s_pair;
  logic [PW:0]   c_twice;
  logic [PW:0]   mag;
  logic          skip;
  logic          out_free;
  logic          accept;
  logic          radius_out;
  logic          multi_in;
  decision_t     dec_next;

  assign s_axis_tready = (state == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{(OUT_DATA_W-2){1'b0}}, out_dec};
  assign out_free      = !out_valid || m_axis_tready;
  assign multi_in      = (dimensions >= DIMS_2D);

  always_comb begin
    s_pair  = (PW+1)'(lo[axis]) + (PW+1)'(hi[axis]);
    c_twice = {pc, 1'b0};
    mag     = (s_pair >= c_twice) ? (s_pair - c_twice) : (c_twice - s_pair);
  end

  assign skip = (pc == '0) && (sum == '0);

  assign radius_out = $signed({radius_sum[31], radius_sum}) >
                      $signed({1'b0, radius_limit, 1'b0});

  always_comb begin
    if (radius_out) begin
      dec_next = DEC_KEEP;
    end else if (!multi) begin
      dec_next = (threshold != '0) ? DEC_DEREFINE : DEC_KEEP;
    end else if (any_above) begin
      dec_next = DEC_REFINE;
    end else if (all_below && (threshold != '0)) begin
      dec_next = DEC_DEREFINE;
    end else begin
      dec_next = DEC_KEEP;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold    <= THRESHOLD_RESET;
      radius_limit <= RADIUS_RESET;
      dimensions   <= DIMS_3D;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_THRESHOLD:  threshold    <= cfg_data;
        REG_RADIUS:     radius_limit <= cfg_data[30:0];
        REG_DIMENSIONS: dimensions   <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      ret       <= ST_IDLE;
      pvalid    <= 1'b0;
      any_above <= 1'b0;
      all_below <= 1'b1;
      out_valid <= 1'b0;
    end else begin
      pvalid <= (state == ST_MUL);
      if (pvalid) begin
        acc <= acc + (ACCW'(prod) << {sh, 5'b0});
      end
      if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            pc         <= PW'(s_axis_tdata[31:0]);
            lo[0]      <= PW'(s_axis_tdata[63:32]);
            hi[0]      <= PW'(s_axis_tdata[95:64]);
            lo[1]      <= PW'(s_axis_tdata[127:96]);
            hi[1]      <= PW'(s_axis_tdata[159:128]);
            lo[2]      <= PW'(s_axis_tdata[191:160]);
            hi[2]      <= PW'(s_axis_tdata[223:192]);
            inv[0]     <= s_axis_tdata[255:224];
            inv[1]     <= s_axis_tdata[287:256];
            inv[2]     <= s_axis_tdata[319:288];
            radius_sum <= s_axis_tdata[351:320];
            last       <= s_axis_tlast;
            multi      <= multi_in;
            axis       <= 2'd0;
            axis_last  <= (dimensions == DIMS_3D) ? 2'd2 : 2'd1;
            sum        <= '0;
            if (multi_in) begin
              state <= ST_MAG;
            end else if (s_axis_tlast) begin
              state <= ST_DECIDE;
            end
          end
        end
        ST_MAG: begin
          opa     <= OPW'(mag);
          opb     <= OPW'(inv[axis]);
          acc     <= '0;
          ia      <= '0;
          ja      <= '0;
          ia_last <= CW'(LA - 1);
          ja_last <= '0;
          ret     <= ST_SQ;
          state   <= ST_MUL;
        end
        ST_MUL: begin
          prod <= 64'(opa[ia]) * 64'(opb[ja]);
          sh   <= SHW'(ia) + SHW'(ja);
          if (ja == ja_last) begin
            ja <= '0;
            if (ia == ia_last) begin
              state <= ST_MWAIT;
            end else begin
              ia <= CW'(ia + 1'b1);
            end
          end else begin
            ja <= CW'(ja + 1'b1);
          end
        end
        ST_MWAIT: begin
          state <= ret;
        end
        ST_SQ: begin
          opa     <= acc[OPW-1:0];
          opb     <= acc[OPW-1:0];
          acc     <= '0;
          ia      <= '0;
          ja      <= '0;
          ia_last <= CW'(L - 1);
          ja_last <= CW'(L - 1);
          ret     <= ST_ADD;
          state   <= ST_MUL;
        end
        ST_ADD: begin
          sum  <= sum + SUMW'(acc);
          axis <= axis + 2'd1;
          if (axis == axis_last) begin
            state <= ST_QT;
          end else begin
            state <= ST_MAG;
          end
        end
        ST_QT: begin
          opa     <= OPW'(threshold);
          opb     <= OPW'(pc);
          acc     <= '0;
          ia      <= '0;
          ja      <= '0;
          ia_last <= '0;
          ja_last <= CW'(LP - 1);
          ret     <= ST_QSQ;
          state   <= ST_MUL;
        end
        ST_QSQ: begin
          opa     <= acc[OPW-1:0];
          opb     <= acc[OPW-1:0];
          acc     <= '0;
          ia      <= '0;
          ja      <= '0;
          ia_last <= CW'(LQ - 1);
          ja_last <= CW'(LQ - 1);
          ret     <= ST_CMPA;
          state   <= ST_MUL;
        end
        ST_CMPA: begin
          if (!skip && (sum > SUMW'(acc))) begin
            any_above <= 1'b1;
          end
          state <= ST_CMPB;
        end
        ST_CMPB: begin
          if (!skip && ({sum, 4'b0} >= (SUMW+4)'(acc))) begin
            all_below <= 1'b0;
          end
          state <= last ? ST_DECIDE : ST_IDLE;
        end
        ST_DECIDE: begin
          if (out_free) begin
            out_valid <= 1'b1;
            out_dec   <= dec_next;
            any_above <= 1'b0;
            all_below <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // An above cell is never below, so once the second compare of a cell is done the two
  // block flags never hold together.
  `ASSERT_IMPL(a_flags_exclusive, any_above && (state != ST_CMPB), !all_below,
               "refine and derefine flags both set")
  // Issuing a decision restarts the block flags.
  `ASSERT_NEXT(a_flags_cleared, (state == ST_DECIDE) && out_free,
               !any_above && all_below && out_valid, "flags not restarted after decision")
  // Only the three defined decision codes leave the block.
  `ASSERT_IMPL(a_decision_code, m_axis_tvalid, m_axis_tdata[1:0] != 2'd3,
               "undefined decision code")
  // A decision in 1D mode ignores the flags and is never refine.
  `ASSERT_IMPL(a_one_dim_no_refine, (state == ST_DECIDE) && !multi, dec_next != DEC_REFINE,
               "refine decided in 1D mode")

endmodule
